// File: rtl/htdr_pkg.sv
package htdr_pkg;
  localparam int unsigned HW = 16;
  localparam int unsigned CW = 17;
  localparam int unsigned CAP = 65536;
  localparam int unsigned EW = 33;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;

  localparam logic [2:0] CMD_ADD_AUTO = 3'd0;
  localparam logic [2:0] CMD_ADD_AT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_FIND = 3'd3;
  localparam logic [2:0] CMD_RESERVE = 3'd4;
  localparam logic [2:0] CMD_RELEASE = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_BADCOUNT = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_STALE = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [31:0] object_id;
    logic [HW-1:0] handle;
    logic [CW-1:0] count;
  } req_t;

  typedef struct packed {
    logic [HW-1:0] handle_out;
    logic [31:0] object_out;
    logic [2:0] status;
    logic [CW-1:0] in_use_total;
    logic [CW-1:0] free_total;
  } rsp_t;
endpackage

// File: rtl/htdr_if.sv
interface htdr_req_if import htdr_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface htdr_rsp_if import htdr_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/handle_table_deferred_reuse.sv
// Channel | Direction | Payload
// in_     | sink      | cmd, object_id, handle, count
// out_    | source    | handle_out, object_out, status, in_use_total, free_total
// cfg_    | APB slave | recycle_threshold at address 0
// A single-entry request steps through accept, read the table memory, update and respond.
// Reserve writes one entry a cycle; release reads each entry, then clears it if it is reserved.
// A recycle scan reads each table entry once, one per cycle, and writes the free handles into the queue memory.
// Reset is synchronous; an init pass then marks entries 0 to 2 reserved.
// Entries beyond the table are written before they are read.
// One request at a time; a held result stalls the next read only until taken.
module handle_table_deferred_reuse import htdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  htdr_req_if.sink    in_ch,
  htdr_rsp_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_EXEC = 4'd2, S_SCAN = 4'd3,
    S_SCANW = 4'd4, S_POP = 4'd5, S_POPD = 4'd6, S_POPC = 4'd7, S_RSV = 4'd8,
    S_RELR = 4'd9, S_RELW = 4'd10, S_RESP = 4'd11, S_INIT = 4'd12;

  logic [3:0] state_r, state_nxt;
  req_t req_r, req_nxt;
  logic [CW-1:0] thr_r, size_r, size_nxt, used_r, used_nxt, rsvd_r, rsvd_nxt;
  logic [CW-1:0] fill_r, fill_nxt, idx_r, idx_nxt, end_r, end_nxt;
  logic [HW-1:0] head_r, head_nxt, hq_r, hq_nxt;
  logic reuse_r, reuse_nxt;
  rsp_t rsp_r, rsp_nxt;
  logic ov_r, ov_nxt;

  logic t_we, q_we;
  logic [HW-1:0] t_wa, t_ra, q_wa, q_ra, q_rd;
  logic [EW-1:0] t_wd, t_rd;
  logic [HW-1:0] q_wd;

  htdr_ram #(.WIDTH(EW), .DEPTH(CAP)) u_tab (.clk(clk), .we(t_we), .waddr(t_wa),
    .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  htdr_ram #(.WIDTH(HW), .DEPTH(CAP)) u_q (.clk(clk), .we(q_we), .waddr(q_wa),
    .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_THRESHOLD) ? {15'd0, thr_r} : 32'd0;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = rsp_r;

  logic t_free, t_rsv;
  logic [31:0] t_obj;
  logic [CW-1:0] freec;
  assign t_rsv = t_rd[32];
  assign t_obj = t_rd[31:0];
  assign t_free = !t_rsv && (t_obj == 32'd0);
  assign freec = size_r - used_r - rsvd_r;

  always_comb begin
    state_nxt = state_r; req_nxt = req_r; size_nxt = size_r; used_nxt = used_r;
    rsvd_nxt = rsvd_r; fill_nxt = fill_r; idx_nxt = idx_r; end_nxt = end_r;
    head_nxt = head_r; hq_nxt = hq_r; reuse_nxt = reuse_r; rsp_nxt = rsp_r;
    ov_nxt = ov_r;
    t_we = 1'b0; t_wa = req_r.handle; t_wd = '0; t_ra = req_r.handle;
    q_we = 1'b0; q_wa = fill_r[HW-1:0]; q_wd = idx_r[HW-1:0]; q_ra = head_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    rsp_nxt.handle_out = '0; rsp_nxt.object_out = '0; rsp_nxt.status = ST_REJECT;
    unique case (state_r)
      S_INIT: begin
        t_we = 1'b1; t_wa = idx_r[HW-1:0]; t_wd = {1'b1, 32'd0};
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CW'(2)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        rsp_nxt = rsp_r;
        if (in_ch.valid) begin
          req_nxt = in_ch.data;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rsp_nxt = rsp_r;
        if (!ov_nxt) begin
          rsp_nxt.handle_out = '0; rsp_nxt.object_out = '0; rsp_nxt.status = ST_REJECT;
          unique case (req_r.cmd)
            CMD_ADD_AUTO: begin
              if (req_r.object_id == 32'd0) state_nxt = S_RESP;
              else if (!reuse_r && freec >= thr_r) begin
                reuse_nxt = 1'b1; head_nxt = '0; fill_nxt = '0; idx_nxt = '0;
                state_nxt = S_SCAN;
              end else state_nxt = S_POP;
            end
            CMD_ADD_AT, CMD_REMOVE, CMD_FIND: state_nxt = S_EXEC;
            CMD_RESERVE: begin
              idx_nxt = size_r;
              if (req_r.count == '0) begin
                rsp_nxt.status = ST_BADCOUNT; state_nxt = S_RESP;
                rsp_nxt.handle_out = '0; rsp_nxt.object_out = '0;
              end else if ({1'b0, req_r.count} > 18'(CAP) - {1'b0, size_r}) begin
                rsp_nxt.status = ST_FULL; state_nxt = S_RESP;
                rsp_nxt.handle_out = '0; rsp_nxt.object_out = '0;
              end else state_nxt = S_RSV;
            end
            CMD_RELEASE: begin
              idx_nxt = {1'b0, req_r.handle};
              if ({1'b0, req_r.handle} + {1'b0, req_r.count} > {1'b0, size_r})
                end_nxt = size_r;
              else end_nxt = CW'({1'b0, req_r.handle} + {1'b0, req_r.count});
              state_nxt = S_RELR;
            end
            default: begin
              rsp_nxt.status = ST_REJECT; rsp_nxt.handle_out = '0;
              rsp_nxt.object_out = '0; state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        if (req_r.cmd == CMD_ADD_AT) begin
          if (req_r.object_id != 32'd0 && {1'b0, req_r.handle} < size_r &&
              (t_rsv || t_obj == 32'd0)) begin
            if (t_rsv) rsvd_nxt = rsvd_r - 1'b1;
            used_nxt = used_r + 1'b1;
            t_we = 1'b1; t_wd = {1'b0, req_r.object_id};
            rsp_nxt.handle_out = req_r.handle; rsp_nxt.status = ST_OK;
          end
        end else if ({1'b0, req_r.handle} < size_r && !t_rsv && t_obj != 32'd0) begin
          rsp_nxt.object_out = t_obj; rsp_nxt.status = ST_OK;
          if (req_r.cmd == CMD_REMOVE) begin
            t_we = 1'b1; t_wd = '0; used_nxt = used_r - 1'b1;
          end
        end
      end
      S_SCAN: begin
        t_ra = idx_r[HW-1:0];
        if (idx_r >= size_r) state_nxt = S_POP;
        else state_nxt = S_SCANW;
      end
      S_SCANW: begin
        q_we = t_free;
        if (t_free) fill_nxt = fill_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        t_ra = idx_nxt[HW-1:0];
        if (idx_nxt >= size_r) state_nxt = S_POP;
      end
      S_POP: begin
        if ({1'b0, head_r} >= fill_r || !reuse_r) begin
          reuse_nxt = 1'b0;
          state_nxt = S_RESP;
          if (size_r >= CW'(CAP)) rsp_nxt.status = ST_FULL;
          else begin
            t_we = 1'b1; t_wa = size_r[HW-1:0]; t_wd = {1'b0, req_r.object_id};
            size_nxt = size_r + 1'b1; used_nxt = used_r + 1'b1;
            rsp_nxt.handle_out = size_r[HW-1:0]; rsp_nxt.status = ST_OK;
          end
        end else state_nxt = S_POPD;
      end
      S_POPD: begin
        hq_nxt = q_rd; t_ra = q_rd;
        if ({1'b0, head_r} + 1'b1 >= fill_r) begin
          head_nxt = '0; fill_nxt = '0;
        end else head_nxt = head_r + 1'b1;
        state_nxt = S_POPC;
      end
      S_POPC: begin
        state_nxt = S_RESP;
        if ({1'b0, hq_r} >= size_r || !t_free) rsp_nxt.status = ST_STALE;
        else begin
          t_we = 1'b1; t_wa = hq_r; t_wd = {1'b0, req_r.object_id};
          used_nxt = used_r + 1'b1;
          rsp_nxt.handle_out = hq_r; rsp_nxt.status = ST_OK;
        end
      end
      S_RSV: begin
        t_we = 1'b1; t_wa = idx_r[HW-1:0]; t_wd = {1'b1, 32'd0};
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt - size_r == req_r.count) begin
          rsp_nxt.handle_out = size_r[HW-1:0]; rsp_nxt.status = ST_OK;
          size_nxt = idx_nxt; rsvd_nxt = rsvd_r + req_r.count;
          state_nxt = S_RESP;
        end
      end
      S_RELR: begin
        t_ra = idx_r[HW-1:0];
        if (idx_r >= end_r) begin
          rsp_nxt.status = ST_OK; state_nxt = S_RESP;
        end else state_nxt = S_RELW;
      end
      S_RELW: begin
        if (t_rsv) begin
          t_we = 1'b1; t_wa = idx_r[HW-1:0]; t_wd = '0; rsvd_nxt = rsvd_r - 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_RELR;
      end
      S_RESP: begin
        rsp_nxt = rsp_r;
        rsp_nxt.in_use_total = used_r;
        rsp_nxt.free_total = freec;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; size_r <= CW'(3); used_r <= '0; rsvd_r <= CW'(3);
      reuse_r <= 1'b0; head_r <= '0; fill_r <= '0; ov_r <= 1'b0;
      thr_r <= CW'(CAP); idx_r <= '0; end_r <= '0;
    end else begin
      state_r <= state_nxt; size_r <= size_nxt; used_r <= used_nxt; rsvd_r <= rsvd_nxt;
      reuse_r <= reuse_nxt; head_r <= head_nxt; fill_r <= fill_nxt; ov_r <= ov_nxt;
      idx_r <= idx_nxt; end_r <= end_nxt;
      if (cfg_wr && cfg_paddr == REG_THRESHOLD) thr_r <= cfg_pwdata[CW-1:0];
    end
    req_r <= req_nxt; rsp_r <= rsp_nxt; hq_r <= hq_nxt;
  end

`ifndef SYNTH
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    used_r + rsvd_r <= size_r) else $error("counts exceed table size");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r) else $error("result dropped");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= size_r) else $error("queue overfilled");
`endif
endmodule

// File: rtl/htdr_ram.sv
module htdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import htdr_pkg::*;

  localparam int unsigned IDLE_LIMIT = 600000;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  class handle_table_mirror;
    logic [31:0] obj_of[CAP];
    bit held[CAP];
    logic [HW-1:0] recycle_list[CAP];
    int unsigned tsize, used, resv, rhead, rfill, thresh;
    bit reuse;
    rsp_t awaited[$];
    int errors, mismatches;

    function new();
      for (int i = 0; i < CAP; i++) begin
        obj_of[i] = '0;
        held[i] = 1'b0;
      end
      held[0] = 1'b1;
      held[1] = 1'b1;
      held[2] = 1'b1;
      tsize = 3;
      used = 0;
      resv = 3;
      rhead = 0;
      rfill = 0;
      thresh = 65536;
      reuse = 1'b0;
      errors = 0;
      mismatches = 0;
    endfunction

    function bit is_free(int unsigned h);
      return !held[h] && obj_of[h] == '0;
    endfunction

    function void bind_entry(int unsigned h, logic [31:0] o);
      obj_of[h] = o;
      held[h] = 1'b0;
      used++;
    endfunction

    function logic [2:0] auto_add(logic [31:0] o, output logic [HW-1:0] h);
      int unsigned pick;
      h = '0;
      if (!reuse && (tsize - used - resv) >= thresh) begin
        reuse = 1'b1;
        rhead = 0;
        rfill = 0;
        for (int unsigned i = 0; i < tsize; i++) begin
          if (is_free(i)) begin
            recycle_list[rfill] = i[HW-1:0];
            rfill++;
          end
        end
      end
      if (rhead >= rfill) reuse = 1'b0;
      if (reuse) begin
        pick = recycle_list[rhead];
        rhead++;
        if (rhead >= rfill) begin
          rhead = 0;
          rfill = 0;
        end
        if (pick >= tsize || !is_free(pick)) return ST_STALE;
        bind_entry(pick, o);
        h = pick[HW-1:0];
        return ST_OK;
      end
      if (tsize >= CAP) return ST_FULL;
      pick = tsize;
      tsize++;
      obj_of[pick] = '0;
      held[pick] = 1'b0;
      bind_entry(pick, o);
      h = pick[HW-1:0];
      return ST_OK;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int unsigned h, cnt, endp;
      e = '0;
      e.status = ST_REJECT;
      h = r.handle;
      cnt = r.count;
      case (r.cmd)
        CMD_ADD_AUTO: begin
          if (r.object_id != '0) e.status = auto_add(r.object_id, e.handle_out);
        end
        CMD_ADD_AT: begin
          if (r.object_id != '0 && h < tsize) begin
            if (held[h]) begin
              resv--;
              bind_entry(h, r.object_id);
              e.handle_out = r.handle;
              e.status = ST_OK;
            end else if (obj_of[h] == '0) begin
              bind_entry(h, r.object_id);
              e.handle_out = r.handle;
              e.status = ST_OK;
            end
          end
        end
        CMD_REMOVE, CMD_FIND: begin
          if (h < tsize && !held[h]) e.object_out = obj_of[h];
          if (e.object_out != '0) begin
            e.status = ST_OK;
            if (r.cmd == CMD_REMOVE) begin
              obj_of[h] = '0;
              used--;
            end
          end
        end
        CMD_RESERVE: begin
          if (cnt == 0) begin
            e.status = ST_BADCOUNT;
          end else if (cnt > CAP - tsize) begin
            e.status = ST_FULL;
          end else begin
            e.handle_out = tsize[HW-1:0];
            for (int unsigned i = 0; i < cnt; i++) begin
              obj_of[tsize + i] = '0;
              held[tsize + i] = 1'b1;
            end
            tsize += cnt;
            resv += cnt;
            e.status = ST_OK;
          end
        end
        CMD_RELEASE: begin
          endp = h + cnt;
          if (endp > tsize) endp = tsize;
          for (int unsigned k = h; k < endp; k++) begin
            if (held[k]) begin
              held[k] = 1'b0;
              obj_of[k] = '0;
              resv--;
            end
          end
          e.status = ST_OK;
        end
        default: ;
      endcase
      e.in_use_total = used[CW-1:0];
      e.free_total = CW'(tsize - used - resv);
      awaited.insert(awaited.size(), e);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("unexpected reply: handle %0d object %h status %0d", got.handle_out,
                 got.object_out, got.status);
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      if (got.handle_out !== e.handle_out || got.object_out !== e.object_out ||
          got.status !== e.status || got.in_use_total !== e.in_use_total ||
          got.free_total !== e.free_total) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp h=%0d o=%h st=%0d used=%0d free=%0d, ",
                   e.handle_out, e.object_out, e.status, e.in_use_total, e.free_total,
                   "got h=%0d o=%h st=%0d used=%0d free=%0d",
                   got.handle_out, got.object_out, got.status, got.in_use_total,
                   got.free_total);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  bit burst = 1'b0;
  int unsigned idle_cycles = 0;

  handle_table_mirror mirror = new();

  htdr_req_if req_ch();
  htdr_rsp_if rsp_ch();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  always #4 clk = ~clk;

  handle_table_deferred_reuse i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(rsp_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) mirror.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) mirror.check_reply(rsp_ch.data);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic send_request(logic [2:0] cmd, logic [31:0] obj, logic [HW-1:0] h,
                              logic [CW-1:0] cnt);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.data.cmd = cmd;
    req_ch.data.object_id = obj;
    req_ch.data.handle = h;
    req_ch.data.count = cnt;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle_and_set_threshold(logic [31:0] value);
    req_ch.valid = 1'b0;
    while (mirror.awaited.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = REG_THRESHOLD;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mirror.thresh = value & 32'h1FFFF;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic send_random();
    int unsigned k;
    logic [2:0] cmd;
    logic [31:0] obj;
    logic [HW-1:0] h;
    logic [CW-1:0] cnt;
    k = $urandom_range(0, 99);
    obj = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
    h = ($urandom_range(0, 7) == 0) ? HW'($urandom) : HW'($urandom_range(0, mirror.tsize + 1));
    cnt = ($urandom_range(0, 15) == 0) ? CW'(0) : CW'($urandom_range(1, 6));
    if (k < 35) cmd = CMD_ADD_AUTO;
    else if (k < 50) cmd = CMD_ADD_AT;
    else if (k < 70) cmd = CMD_REMOVE;
    else if (k < 80) cmd = CMD_FIND;
    else if (k < 88) cmd = CMD_RESERVE;
    else if (k < 96) begin
      cmd = CMD_RELEASE;
      if ($urandom_range(0, 3) == 0) cnt = CW'($urandom);
    end else cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    send_request(cmd, obj, h, cnt);
  endtask

  initial begin
    int unsigned thresholds[6];
    thresholds = '{1, 3, 0, 12, 65536, 2};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_request(CMD_FIND, 32'h1234, 16'd0, 17'd0);
    send_request(CMD_REMOVE, 32'h0, 16'd5, 17'd0);
    send_request(CMD_ADD_AUTO, 32'h0, 16'd0, 17'd0);
    send_request(CMD_ADD_AUTO, 32'hFFFFFFFF, 16'hFFFF, 17'h1FFFF);
    send_request(CMD_ADD_AUTO, 32'h1, 16'd0, 17'd0);
    send_request(CMD_ADD_AT, 32'hA5A5A5A5, 16'd0, 17'd0);
    send_request(CMD_ADD_AT, 32'h77, 16'd4, 17'd0);
    send_request(CMD_ADD_AT, 32'h55, 16'hFFFF, 17'd0);
    send_request(CMD_FIND, 32'h0, 16'd3, 17'd0);
    send_request(CMD_REMOVE, 32'h0, 16'd3, 17'd0);
    send_request(CMD_FIND, 32'h0, 16'd3, 17'd0);
    send_request(CMD_RESERVE, 32'h0, 16'd0, 17'd0);
    send_request(CMD_RESERVE, 32'h0, 16'd0, 17'h10000);
    send_request(CMD_RESERVE, 32'h0, 16'd0, 17'd3);
    send_request(CMD_RELEASE, 32'h0, 16'd6, 17'd2);
    send_request(CMD_RELEASE, 32'h0, 16'd7, 17'd0);
    send_request(CMD_RELEASE, 32'h0, 16'hFFFF, 17'h10000);
    send_request(CMD_ADD_AT, 32'h5A5A5A5A, 16'd7, 17'd0);
    send_request(CMD_SPARE_A, 32'h9, 16'd1, 17'd1);
    send_request(CMD_SPARE_B, 32'h9, 16'd1, 17'd1);
    send_request(CMD_REMOVE, 32'h0, 16'd0, 17'd0);
    send_request(CMD_FIND, 32'h0, 16'd6, 17'd0);

    for (int p = 0; p < 6; p++) begin
      settle_and_set_threshold(thresholds[p]);
      for (int i = 0; i < 117; i++) begin
        burst = (i % 60) < 12;
        send_random();
      end
    end
    burst = 1'b0;

    settle_and_set_threshold(65536);
    send_request(CMD_RESERVE, 32'h0, 16'd0, CW'(CAP - mirror.tsize));
    send_request(CMD_ADD_AUTO, 32'hC0FFEE, 16'd0, 17'd0);
    send_request(CMD_RESERVE, 32'h0, 16'd0, 17'd1);
    send_request(CMD_RELEASE, 32'h0, 16'd0, 17'h10000);
    settle_and_set_threshold(1);
    send_request(CMD_ADD_AUTO, 32'hBEEF, 16'd0, 17'd0);
    send_request(CMD_ADD_AUTO, 32'hBEF0, 16'd0, 17'd0);
    send_request(CMD_FIND, 32'h0, 16'hFFFF, 17'd0);

    req_ch.valid = 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
